FILE: rtl/cla_pkg.sv
// shared types and constants of the command line assembler
package cla_pkg;

    localparam int CHAR_W     = 8;
    localparam int IDX_W      = 7;
    localparam int LEN_W      = 6;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int JOBQ_DEPTH = 2;
    localparam int OUT_DEPTH  = 4;

    localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;

    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LF_TERMINATES = 2'd1;

    localparam logic [IDX_W-1:0] CAP_RESET = 7'd64;

    typedef struct packed {
        logic                line;
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    len;
    } job_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CHAR_W-1:0]   line_char;
        logic                char_valid;
        logic                last;
        logic [LEN_W-1:0]    line_length;
    } result_t;

endpackage

FILE: rtl/cla_line_store.sv
// line store memory, one write port and two registered read ports
module cla_line_store #(
    parameter int LINE_DEPTH = 64
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [cla_pkg::IDX_W-1:0]   wr_idx,
    input  logic [cla_pkg::CHAR_W-1:0]  wr_data,
    input  logic [cla_pkg::IDX_W-1:0]   rd_a_idx,
    output logic [cla_pkg::CHAR_W-1:0]  rd_a_data,
    input  logic [cla_pkg::IDX_W-1:0]   rd_b_idx,
    output logic [cla_pkg::CHAR_W-1:0]  rd_b_data
);
    import cla_pkg::*;

    localparam int MEM_LIMIT = 1 << IDX_W;
    localparam int MEM_DEPTH = (LINE_DEPTH > MEM_LIMIT) ? MEM_LIMIT : LINE_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);

    logic [CHAR_W-1:0] mem [MEM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx[AW-1:0]] <= wr_data;
        end
        rd_a_data <= mem[rd_a_idx[AW-1:0]];
        rd_b_data <= mem[rd_b_idx[AW-1:0]];
    end

endmodule

FILE: rtl/cla_job_queue.sv
// short job queue between the front and the back
module cla_job_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cla_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output cla_pkg::job_t pop_job,
    output logic          empty
);
    import cla_pkg::*;

    localparam int PW = $clog2(JOBQ_DEPTH);
    localparam int CW = $clog2(JOBQ_DEPTH + 1);

    job_t          q_reg [JOBQ_DEPTH];
    logic [PW-1:0] wp_reg;
    logic [PW-1:0] rp_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(JOBQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = q_reg[rp_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= wp_reg + PW'(1);
            end
            if (do_pop)
            begin
                rp_reg <= rp_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wp_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/cla_front.sv
// front: accepts characters, keeps line state, writes the line store, queues jobs
module cla_front #(
    parameter int LINE_DEPTH = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        command,
    input  logic [cla_pkg::CHAR_W-1:0]  char_code,
    input  logic [cla_pkg::IDX_W-1:0]   line_capacity,
    input  logic                        lf_terminates,
    output logic                        wr_en,
    output logic [cla_pkg::IDX_W-1:0]   wr_idx,
    output logic [cla_pkg::CHAR_W-1:0]  wr_data,
    output logic [cla_pkg::IDX_W-1:0]   rd_idx,
    input  logic [cla_pkg::CHAR_W-1:0]  rd_data,
    output logic                        job_push,
    output cla_pkg::job_t               job,
    input  logic                        job_full,
    input  logic                        line_done
);
    import cla_pkg::*;

    localparam int IDX_MAX = (1 << IDX_W) - 1;
    localparam logic [IDX_W-1:0] CAP_MAX = IDX_W'((LINE_DEPTH > IDX_MAX) ? IDX_MAX : LINE_DEPTH);

    logic [IDX_W-1:0]  wi_reg;
    logic [IDX_W-1:0]  wi_next;
    logic              par_reg;
    logic              par_next;
    logic              full_reg;
    logic              full_next;
    logic              pend_reg;
    logic              pend_next;
    logic              byp_reg;
    logic [CHAR_W-1:0] byp_char_reg;
    logic [CHAR_W-1:0] top_char;
    logic [IDX_W-1:0]  cap_eff;
    logic              accept;
    logic              is_eol;
    logic              par_t;
    logic              fin;

    function automatic logic no_room(input logic [IDX_W-1:0] w, input logic [IDX_W-1:0] cap);
        return !(({1'b0, w} + (IDX_W+1)'(1)) < {1'b0, cap});
    endfunction

    assign cap_eff  = (line_capacity > CAP_MAX) ? CAP_MAX : line_capacity;
    assign full     = job_full || (pend_reg && !line_done);
    assign accept   = push && !full;
    assign is_eol   = (char_code == CH_CR) || (char_code == CH_LF);
    assign top_char = byp_reg ? byp_char_reg : rd_data;
    assign wr_idx   = wi_reg;
    assign wr_data  = char_code;
    assign rd_idx   = wi_next - IDX_W'(1);
    assign job_push = accept;

    always_comb
    begin
        wi_next    = wi_reg;
        par_next   = par_reg;
        full_next  = full_reg;
        pend_next  = pend_reg && !line_done;
        wr_en      = 1'b0;
        par_t      = par_reg ^ (char_code == CH_QUOTE);
        fin        = 1'b0;
        job.line   = 1'b0;
        job.status = ST_INCOMPLETE;
        job.len    = '0;
        if (accept)
        begin
            if (command == CMD_CLEAR)
            begin
                wi_next   = '0;
                par_next  = 1'b0;
                full_next = 1'b0;
            end
            else if (full_reg || no_room(wi_reg, cap_eff))
            begin
                full_next  = 1'b1;
                job.status = ST_FULL;
            end
            else
            begin
                if (is_eol && !lf_terminates)
                begin
                    wi_next  = '0;
                    par_next = 1'b0;
                end
                else if (char_code == CH_BS)
                begin
                    if (wi_reg != '0)
                    begin
                        wi_next = wi_reg - IDX_W'(1);
                        if (top_char == CH_QUOTE)
                        begin
                            par_next = !par_reg;
                        end
                    end
                end
                else if (!par_t && ((char_code == CH_SEMI) || is_eol))
                begin
                    fin        = 1'b1;
                    wi_next    = '0;
                    par_next   = 1'b0;
                    job.status = ST_DONE;
                    if (wi_reg != '0)
                    begin
                        job.line  = 1'b1;
                        job.len   = wi_reg;
                        pend_next = 1'b1;
                    end
                end
                else
                begin
                    wr_en    = 1'b1;
                    wi_next  = wi_reg + IDX_W'(1);
                    par_next = par_t;
                end
                if (!fin && no_room(wi_next, cap_eff))
                begin
                    full_next  = 1'b1;
                    job.status = ST_FULL;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg   <= '0;
            par_reg  <= 1'b0;
            full_reg <= 1'b0;
            pend_reg <= 1'b0;
            byp_reg  <= 1'b0;
        end
        else
        begin
            wi_reg   <= wi_next;
            par_reg  <= par_next;
            full_reg <= full_next;
            pend_reg <= pend_next;
            byp_reg  <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_char_reg <= char_code;
    end

    // store is never written while a finished line is still being read out
    a_no_write_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !pend_reg || line_done)
        else $error("line store written while a line is pending");

    // writes stay below the capacity in use
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (({1'b0, wr_idx} + (IDX_W+1)'(1)) < {1'b0, cap_eff}))
        else $error("line store written beyond capacity");

endmodule

FILE: rtl/cla_back.sv
// back: runs queued jobs, reads finished lines out of the store, result queue
module cla_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        job_empty,
    input  cla_pkg::job_t               job,
    output logic                        job_pop,
    output logic [cla_pkg::IDX_W-1:0]   rd_idx,
    input  logic [cla_pkg::CHAR_W-1:0]  rd_data,
    output logic                        line_done,
    input  logic                        pop,
    output logic                        empty,
    output cla_pkg::result_t            res
);
    import cla_pkg::*;

    localparam int PW = $clog2(OUT_DEPTH);
    localparam int CW = $clog2(OUT_DEPTH + 1);

    logic             busy_reg;
    logic             busy_next;
    logic [IDX_W-1:0] len_reg;
    logic [IDX_W-1:0] len_next;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] k_next;
    logic             done_reg;
    logic             done_next;
    logic             s1_valid_reg;
    result_t          s1_reg;
    result_t          desc;
    result_t          land;
    logic             issue;
    logic             room;
    logic             is_last;
    result_t          fifo_reg [OUT_DEPTH];
    logic [PW-1:0]    wp_reg;
    logic [PW-1:0]    rp_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             pop_f;

    assign room      = ((CW+1)'(count_reg) + (CW+1)'(s1_valid_reg)) < (CW+1)'(OUT_DEPTH);
    assign is_last   = (({1'b0, k_reg} + (IDX_W+1)'(1)) == {1'b0, len_reg});
    assign rd_idx    = k_reg;
    assign line_done = done_reg;
    assign empty     = (count_reg == '0);
    assign pop_f     = pop && !empty;
    assign res       = fifo_reg[rp_reg];

    always_comb
    begin
        issue     = 1'b0;
        job_pop   = 1'b0;
        busy_next = busy_reg;
        len_next  = len_reg;
        k_next    = k_reg;
        done_next = 1'b0;
        desc      = '0;
        if (room)
        begin
            if (busy_reg)
            begin
                issue            = 1'b1;
                desc.status      = ST_DONE;
                desc.char_valid  = 1'b1;
                desc.last        = is_last;
                desc.line_length = len_reg[LEN_W-1:0];
                k_next           = k_reg + IDX_W'(1);
                if (is_last)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
            else if (!job_empty)
            begin
                job_pop = 1'b1;
                if (job.line)
                begin
                    busy_next = 1'b1;
                    len_next  = job.len;
                    k_next    = '0;
                end
                else
                begin
                    issue       = 1'b1;
                    desc.status = job.status;
                    desc.last   = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        land = s1_reg;
        land.line_char = s1_reg.char_valid ? rd_data : '0;
    end

    always_comb
    begin
        count_next = count_reg;
        if (s1_valid_reg && !pop_f)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop_f && !s1_valid_reg)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            k_reg        <= '0;
            done_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            wp_reg       <= '0;
            rp_reg       <= '0;
            count_reg    <= '0;
        end
        else
        begin
            busy_reg     <= busy_next;
            k_reg        <= k_next;
            done_reg     <= done_next;
            s1_valid_reg <= issue;
            if (s1_valid_reg)
            begin
                wp_reg <= wp_reg + PW'(1);
            end
            if (pop_f)
            begin
                rp_reg <= rp_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        s1_reg  <= desc;
        if (s1_valid_reg)
        begin
            fifo_reg[wp_reg] <= land;
        end
    end

    // a beat landing from the read stage always finds a free slot
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (count_reg < CW'(OUT_DEPTH)) || pop_f)
        else $error("result queue overflow");

    // line done follows the final read of a line
    a_done_after_line: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("line done without a line in progress");

endmodule

FILE: rtl/command_line_assembler.sv
// top level of the command line assembler
// Characters are taken one per cycle while full is low; each result beat passes the job
// queue, the read stage register and the result queue. A line end outside quotes closing
// a non-empty line gives one beat per stored character, read from the line store at one
// per cycle through its second read port while the result queue has room; full stays
// high from the accepted line end until the last character of that line has been read.
// Full is also high while the two-entry job queue between the front and the back is full,
// which happens when results are not popped. Configuration writes are taken in any cycle.
module command_line_assembler #(
    parameter int LINE_DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            command,
    input  logic [cla_pkg::CHAR_W-1:0]      char_code,
    output logic                            empty,
    input  logic                            pop,
    output logic [cla_pkg::STATUS_W-1:0]    status,
    output logic [cla_pkg::CHAR_W-1:0]      line_char,
    output logic                            char_valid,
    output logic                            last,
    output logic [cla_pkg::LEN_W-1:0]       line_length,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cla_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cla_pkg::IDX_W-1:0]       cfg_data
);
    import cla_pkg::*;

    logic [IDX_W-1:0]  line_capacity_reg;
    logic              lf_terminates_reg;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [CHAR_W-1:0] wr_data;
    logic [IDX_W-1:0]  rd_a_idx;
    logic [CHAR_W-1:0] rd_a_data;
    logic [IDX_W-1:0]  rd_b_idx;
    logic [CHAR_W-1:0] rd_b_data;
    logic              job_push;
    job_t              push_job;
    logic              job_full;
    logic              job_pop;
    job_t              pop_job;
    logic              job_empty;
    logic              line_done;
    result_t           res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_capacity_reg <= CAP_RESET;
            lf_terminates_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LINE_CAPACITY: line_capacity_reg <= cfg_data;
                CFG_LF_TERMINATES: lf_terminates_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    cla_front #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .command       (command),
        .char_code     (char_code),
        .line_capacity (line_capacity_reg),
        .lf_terminates (lf_terminates_reg),
        .wr_en         (wr_en),
        .wr_idx        (wr_idx),
        .wr_data       (wr_data),
        .rd_idx        (rd_a_idx),
        .rd_data       (rd_a_data),
        .job_push      (job_push),
        .job           (push_job),
        .job_full      (job_full),
        .line_done     (line_done)
    );

    cla_line_store #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_idx    (wr_idx),
        .wr_data   (wr_data),
        .rd_a_idx  (rd_a_idx),
        .rd_a_data (rd_a_data),
        .rd_b_idx  (rd_b_idx),
        .rd_b_data (rd_b_data)
    );

    cla_job_queue u_jobq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .full     (job_full),
        .pop      (job_pop),
        .pop_job  (pop_job),
        .empty    (job_empty)
    );

    cla_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job       (pop_job),
        .job_pop   (job_pop),
        .rd_idx    (rd_b_idx),
        .rd_data   (rd_b_data),
        .line_done (line_done),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    assign status      = res.status;
    assign line_char   = res.line_char;
    assign char_valid  = res.char_valid;
    assign last        = res.last;
    assign line_length = res.line_length;

endmodule

FILE: verif/tb_top.sv
// testbench for the command line assembler: queued character beats, line prediction, beat checks
module tb_top;
    import cla_pkg::*;

    localparam int DEPTH = 64;
    localparam int SETTLE = 8;
    localparam int DRAIN = 70;
    localparam int HOLD_CYCLES = 90;
    localparam int QUIET_LIMIT = 4000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic              cmd;
        logic [CHAR_W-1:0] code;
    } char_beat_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic                 command = 1'b0;
    logic [CHAR_W-1:0]    char_code = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [CHAR_W-1:0]    line_char;
    logic                 char_valid;
    logic                 last;
    logic [LEN_W-1:0]     line_length;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [IDX_W-1:0]     cfg_data = '0;

    // predicted block state
    logic [CHAR_W-1:0] line_buf [DEPTH];
    int unsigned       wr_idx = 0;
    bit                quote_odd = 0;
    bit                full_seen = 0;
    int unsigned       cap_setting = 64;
    bit                lf_ends = 0;

    char_beat_t pending [$];
    result_t    beats_due [$];
    int         items_queued = 0;
    int         items_taken = 0;
    int         n_fail = 0;
    int         quiet = 0;
    bit         calm_mode = 0;
    bit         hold_req = 0;
    bit         hold_done = 0;
    int         drv_gap = 0;
    int         drv_calm = 0;
    int         mon_gap = 0;
    int         mon_calm = 0;
    int         mon_hold = 0;

    command_line_assembler #(
        .LINE_DEPTH(DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .command    (command),
        .char_code  (char_code),
        .empty      (empty),
        .pop        (pop),
        .status     (status),
        .line_char  (line_char),
        .char_valid (char_valid),
        .last       (last),
        .line_length(line_length),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic bit line_has_no_room();
        int unsigned cap;
        cap = (cap_setting > DEPTH) ? DEPTH : cap_setting;
        return !(wr_idx + 1 < cap);
    endfunction

    function automatic void expect_single(logic [STATUS_W-1:0] st);
        result_t r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        beats_due.push_back(r);
    endfunction

    function automatic void assemble_step(logic cmd, logic [CHAR_W-1:0] ch);
        bit          eol;
        int unsigned len;
        int unsigned k;
        result_t     r;
        eol = (ch == CH_CR) || (ch == CH_LF);
        if (cmd == CMD_CLEAR)
        begin
            wr_idx = 0;
            quote_odd = 0;
            full_seen = 0;
            expect_single(ST_INCOMPLETE);
            return;
        end
        if (full_seen || line_has_no_room())
        begin
            full_seen = 1;
            expect_single(ST_FULL);
            return;
        end
        if (eol && !lf_ends)
        begin
            wr_idx = 0;
            quote_odd = 0;
        end
        else if (ch == CH_BS)
        begin
            if (wr_idx != 0)
            begin
                wr_idx--;
                if (line_buf[wr_idx % DEPTH] == CH_QUOTE)
                    quote_odd = ~quote_odd;
            end
        end
        else
        begin
            if (ch == CH_QUOTE)
                quote_odd = ~quote_odd;
            if (!quote_odd && (ch == CH_SEMI || eol))
            begin
                len = wr_idx;
                wr_idx = 0;
                quote_odd = 0;
                if (len == 0)
                begin
                    expect_single(ST_DONE);
                    return;
                end
                for (k = 0; k < len; k++)
                begin
                    r.status = ST_DONE;
                    r.line_char = line_buf[k % DEPTH];
                    r.char_valid = 1'b1;
                    r.last = (k + 1 == len);
                    r.line_length = len[LEN_W-1:0];
                    beats_due.push_back(r);
                end
                return;
            end
            line_buf[wr_idx % DEPTH] = ch;
            wr_idx = (wr_idx + 1) & 'h7F;
        end
        if (line_has_no_room())
        begin
            full_seen = 1;
            expect_single(ST_FULL);
        end
        else
            expect_single(ST_INCOMPLETE);
    endfunction

    // driver
    always @(posedge clk)
    begin
        char_beat_t nxt;
        bit         go;
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
            begin
                items_taken++;
                assemble_step(command, char_code);
            end
            if (!(push && full))
            begin
                if (pending.size() == 0)
                    push <= 1'b0;
                else
                begin
                    go = 1;
                    if (calm_mode)
                        go = 1;
                    else if (drv_calm > 0)
                        drv_calm--;
                    else if (drv_gap > 0)
                    begin
                        go = 0;
                        drv_gap--;
                    end
                    else if ($urandom_range(0, 4) == 0)
                    begin
                        go = 0;
                        drv_gap = $urandom_range(0, 2);
                    end
                    else if ($urandom_range(0, 24) == 0)
                        drv_calm = $urandom_range(10, 30);
                    if (go)
                    begin
                        nxt = pending.pop_front();
                        command <= nxt.cmd;
                        char_code <= nxt.code;
                        push <= 1'b1;
                    end
                    else
                        push <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (beats_due.size() == 0)
                begin
                    $error("result beat with no expectation");
                    n_fail++;
                end
                else
                begin
                    want = beats_due.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status expected %0d got %0d", want.status, status);
                        n_fail++;
                    end
                    if (line_char !== want.line_char)
                    begin
                        $error("line_char expected %0h got %0h", want.line_char, line_char);
                        n_fail++;
                    end
                    if (char_valid !== want.char_valid)
                    begin
                        $error("char_valid expected %0d got %0d", want.char_valid, char_valid);
                        n_fail++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last expected %0d got %0d", want.last, last);
                        n_fail++;
                    end
                    if (line_length !== want.line_length)
                    begin
                        $error("line_length expected %0d got %0d", want.line_length,
                               line_length);
                        n_fail++;
                    end
                end
            end
            if (hold_req && !hold_done)
            begin
                hold_done = 1;
                mon_hold = HOLD_CYCLES;
            end
            if (mon_hold > 0)
            begin
                mon_hold--;
                pop <= 1'b0;
            end
            else if (calm_mode)
                pop <= 1'b1;
            else if (mon_calm > 0)
            begin
                mon_calm--;
                pop <= 1'b1;
            end
            else if (mon_gap > 0)
            begin
                mon_gap--;
                pop <= 1'b0;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                mon_gap = $urandom_range(0, 2);
                pop <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 24) == 0)
                    mon_calm = $urandom_range(10, 30);
                pop <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        while (quiet < QUIET_LIMIT)
            @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    task automatic add_beat(logic cmd, logic [CHAR_W-1:0] ch);
        char_beat_t b;
        b.cmd = cmd;
        b.code = ch;
        pending.push_back(b);
        items_queued++;
    endtask

    task automatic add_char(logic [CHAR_W-1:0] ch);
        add_beat(1'b0, ch);
    endtask

    task automatic add_clear(logic [CHAR_W-1:0] ch);
        add_beat(CMD_CLEAR, ch);
    endtask

    task automatic add_line(int maxlen);
        int len;
        int i;
        int pick;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, maxlen) : $urandom_range(0, 6);
        for (i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                add_char(CH_QUOTE);
            else if (pick == 1)
                add_char(CH_BS);
            else
                add_char(8'($urandom_range(8'h20, 8'h7E)));
        end
        pick = $urandom_range(0, 3);
        if (pick == 2)
            add_char(CH_CR);
        else if (pick == 3)
            add_char(CH_LF);
        else
            add_char(CH_SEMI);
    endtask

    task automatic add_random(int n, int maxlen);
        int start;
        int pick;
        start = items_queued;
        while (items_queued - start < n)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                add_char(8'($urandom_range(0, 255)));
            else if (pick == 1)
                add_clear(8'($urandom_range(0, 255)));
            else
                add_line(maxlen);
        end
    endtask

    task automatic add_long_line(int n);
        int i;
        add_clear(8'h00);
        for (i = 0; i < n; i++)
            add_char(8'($urandom_range(8'h41, 8'h5A)));
        add_char(CH_SEMI);
    endtask

    task automatic wait_drained(int extra);
        while (items_taken != items_queued || beats_due.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [IDX_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_LINE_CAPACITY)
            cap_setting = val;
        else if (idx == CFG_LF_TERMINATES)
            lf_ends = val[0];
    endtask

    task automatic set_mode(logic [IDX_W-1:0] cap, logic lf);
        wait_drained(SETTLE);
        write_reg(CFG_LINE_CAPACITY, cap);
        write_reg(CFG_LF_TERMINATES, {6'd0, lf});
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: capacity 64, cr/lf discard
        add_char("a");
        add_char("b");
        add_char(CH_SEMI);
        add_char(CH_SEMI);
        add_char(CH_BS);
        add_char("x");
        add_char(CH_BS);
        add_char(CH_SEMI);
        add_char(CH_QUOTE);
        add_char(CH_SEMI);
        add_char(CH_QUOTE);
        add_char(CH_SEMI);
        add_char(CH_QUOTE);
        add_char(CH_BS);
        add_char(CH_SEMI);
        add_char("q");
        add_char(CH_CR);
        add_char(CH_QUOTE);
        add_char(CH_LF);
        add_char(CH_SEMI);
        add_char(8'h00);
        add_char(8'hFF);
        add_char(CH_SEMI);
        add_clear(8'hFF);
        add_random(18, 12);
        hold_req = 1;

        set_mode(7'd2, 1'b1);
        add_char("a");
        add_char("b");
        add_char(CH_SEMI);
        add_clear(CH_SEMI);
        add_char(CH_SEMI);
        add_char(CH_LF);
        add_clear(8'h00);
        add_random(10, 4);

        set_mode(7'd64, 1'b1);
        add_clear(8'h00);
        add_char("a");
        add_char("b");
        add_char(CH_LF);
        add_char(CH_QUOTE);
        add_char(CH_CR);
        add_char(CH_QUOTE);
        add_char(CH_CR);
        add_char(CH_CR);
        add_random(12, 20);
        add_long_line(62);

        set_mode(7'd0, 1'b0);
        add_random(6, 4);

        set_mode(7'd1, 1'b1);
        add_random(6, 4);

        set_mode(7'd127, 1'b0);
        add_clear(8'h00);
        add_random(12, 30);

        set_mode(7'd5, 1'b1);
        add_clear(8'h00);
        add_random(12, 8);

        wait_drained(SETTLE);
        write_reg(CFG_SPARE, 7'h7F);
        set_mode(7'd100, 1'b0);
        calm_mode = 1;
        add_clear(8'h00);
        add_random(20, 16);

        wait_drained(DRAIN);
        if (n_fail == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
